### rtl/core/joystick_axis_deadzone_mapper_top_macros.svh
// Assertion helpers for the joystick axis mapper.
// Both sample on the rising edge of clk and are off while rst_n is low.
`ifndef JOYSTICK_AXIS_DEADZONE_MAPPER_TOP_MACROS_SVH
`define JOYSTICK_AXIS_DEADZONE_MAPPER_TOP_MACROS_SVH

// Same-cycle implication.
`define JADM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define JADM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/jadm_pkg.sv
package jadm_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int AXIS_COUNT  = 4;
  localparam int AXIS_BITS   = 2;
  localparam int CAL_SAMPLES = 32;
  localparam int CAL_SHIFT   = $clog2(CAL_SAMPLES);
  localparam int SUM_BITS    = SAMPLE_BITS + CAL_SHIFT;
  localparam int CNT_BITS    = CAL_SHIFT;
  localparam int DZ_BITS     = 7;
  localparam int PCT_BITS    = 7;                  // quotient magnitude, 0..100
  localparam int POS_BITS    = 8;
  localparam int PROD_BITS   = SAMPLE_BITS + 7;    // |diff| * 100
  localparam int STEP_BITS   = 3;

  localparam logic [SAMPLE_BITS-1:0] MAX_RAW      = '1;
  localparam logic [SAMPLE_BITS-1:0] CENTER_RESET = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
  localparam logic [PROD_BITS-1:0]   FULL_SCALE   = PROD_BITS'(100);
  localparam logic [DZ_BITS-1:0]     DEADZONE_RESET = DZ_BITS'(4);
  localparam logic [CNT_BITS-1:0]    CNT_LAST     = CNT_BITS'(CAL_SAMPLES - 1);
  localparam logic [STEP_BITS-1:0]   STEP_FIRST   = STEP_BITS'(PCT_BITS - 1);

  localparam logic OP_MAP = 1'b0;
  localparam logic OP_CAL = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

### rtl/core/joystick_axis_deadzone_mapper_top.sv
// Joystick axis mapper: a map transaction turns a 12-bit sample into a signed
// percent deflection (-100..+100, zero inside the deadzone) relative to the
// axis center; a calibration transaction accumulates the sample, and every 32nd
// one per axis replaces that axis center with the average. A map transaction
// passes through a setup state, the shared restoring divider at one quotient
// bit per cycle and a finish state, and in_tready returns once it is idle
// again, so the block takes no new transaction before it is through with the
// last; a calibration transaction passes through a setup and a finish state.
// in_tready is high only while no transaction is in progress; a
// finished result waits in the output register, so a new transaction can start
// while it is still unclaimed, and it then holds in its finish cycle until
// that register is free.
`include "joystick_axis_deadzone_mapper_top_macros.svh"

module joystick_axis_deadzone_mapper_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wen,
  input  logic [6:0]  cfg_wdata,   // deadzone threshold in percent
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // axis[1:0], raw_sample[13:2], zero[15:14]
  input  logic        in_tuser,    // operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // axis_out[1:0], position[9:2], center_now[21:10], zero
  output logic        out_tuser    // calibration_done
);

  localparam int SB = jadm_pkg::SAMPLE_BITS;
  localparam int AB = jadm_pkg::AXIS_BITS;
  localparam int PB = jadm_pkg::PROD_BITS;

  jadm_pkg::state_t state_r, state_nxt;

  logic [jadm_pkg::DZ_BITS-1:0]  dz_r;
  logic [SB-1:0]                 center_r [jadm_pkg::AXIS_COUNT];
  logic [jadm_pkg::SUM_BITS-1:0] sum_r    [jadm_pkg::AXIS_COUNT];
  logic [jadm_pkg::CNT_BITS-1:0] count_r  [jadm_pkg::AXIS_COUNT];

  logic          op_r, op_nxt;
  logic [AB-1:0] axis_r, axis_nxt;
  logic [SB-1:0] raw_r, raw_nxt;
  logic          neg_r, neg_nxt;
  logic [PB-1:0] rem_r, rem_nxt;
  logic [PB-1:0] dvs_r, dvs_nxt;
  logic [jadm_pkg::STEP_BITS-1:0] step_r, step_nxt;
  logic [jadm_pkg::PCT_BITS-1:0]  quo_r, quo_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [AB-1:0]                 out_axis_r, out_axis_nxt;
  logic signed [jadm_pkg::POS_BITS-1:0] out_pos_r, out_pos_nxt;
  logic [SB-1:0]                 out_ctr_r, out_ctr_nxt;
  logic                          out_done_r, out_done_nxt;

  logic                          cal_wr;
  logic [SB-1:0]                 cal_center;
  logic [jadm_pkg::SUM_BITS-1:0] cal_sum;
  logic [jadm_pkg::CNT_BITS-1:0] cal_count;

  logic [SB-1:0] ctr;
  logic [SB:0]   diff;
  logic [SB-1:0] mag;
  logic [SB-1:0] span;
  logic          ge;
  logic [jadm_pkg::PCT_BITS-1:0] pct_mag;
  logic          slot_free;

  assign in_tready = (state_r == jadm_pkg::ST_IDLE);
  assign slot_free = !out_valid_r || out_tready;

  assign ctr  = center_r[axis_r];
  assign diff = {1'b0, raw_r} - {1'b0, ctr};
  assign ge   = (rem_r >= dvs_r);
  // quotient never exceeds 100: |diff| is bounded by the span on its side
  assign pct_mag = ({1'b0, quo_r} < {1'b0, dz_r}) ? '0 : quo_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    axis_nxt      = axis_r;
    raw_nxt       = raw_r;
    neg_nxt       = neg_r;
    rem_nxt       = rem_r;
    dvs_nxt       = dvs_r;
    step_nxt      = step_r;
    quo_nxt       = quo_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_axis_nxt  = out_axis_r;
    out_pos_nxt   = out_pos_r;
    out_ctr_nxt   = out_ctr_r;
    out_done_nxt  = out_done_r;
    cal_wr        = 1'b0;
    cal_sum       = sum_r[axis_r] + jadm_pkg::SUM_BITS'(raw_r);
    cal_count     = count_r[axis_r] + 1'b1;
    cal_center    = ctr;
    mag           = diff[SB] ? (ctr - raw_r) : diff[SB-1:0];
    span          = diff[SB] ? ctr : (jadm_pkg::MAX_RAW - ctr);
    if (span == '0) begin
      span = SB'(1);
    end

    case (state_r)
      jadm_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tuser;
          axis_nxt  = in_tdata[AB-1:0];
          raw_nxt   = in_tdata[AB +: SB];
          state_nxt = jadm_pkg::ST_PREP;
        end
      end
      jadm_pkg::ST_PREP: begin
        if (op_r == jadm_pkg::OP_CAL) begin
          cal_wr = 1'b1;
          if (count_r[axis_r] == jadm_pkg::CNT_LAST) begin
            cal_center = cal_sum[jadm_pkg::SUM_BITS-1 -: SB];
            cal_sum    = '0;
            cal_count  = '0;
          end
          state_nxt = jadm_pkg::ST_DONE;
        end else begin
          neg_nxt   = diff[SB];
          rem_nxt   = PB'(mag) * jadm_pkg::FULL_SCALE;
          dvs_nxt   = PB'(span) << jadm_pkg::STEP_FIRST;
          step_nxt  = jadm_pkg::STEP_FIRST;
          quo_nxt   = '0;
          state_nxt = jadm_pkg::ST_DIV;
        end
      end
      jadm_pkg::ST_DIV: begin
        if (ge) begin
          rem_nxt = rem_r - dvs_r;
        end
        quo_nxt  = {quo_r[jadm_pkg::PCT_BITS-2:0], ge};
        dvs_nxt  = dvs_r >> 1;
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = jadm_pkg::ST_DONE;
        end
      end
      jadm_pkg::ST_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_axis_nxt  = axis_r;
          out_ctr_nxt   = ctr;
          if (op_r == jadm_pkg::OP_CAL) begin
            out_pos_nxt  = '0;
            out_done_nxt = (count_r[axis_r] == '0);
          end else begin
            out_done_nxt = 1'b0;
            out_pos_nxt  = neg_r ? -$signed({1'b0, pct_mag}) : $signed({1'b0, pct_mag});
          end
          state_nxt = jadm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = jadm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= jadm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      dz_r        <= jadm_pkg::DEADZONE_RESET;
      for (int i = 0; i < jadm_pkg::AXIS_COUNT; i++) begin
        center_r[i] <= jadm_pkg::CENTER_RESET;
        sum_r[i]    <= '0;
        count_r[i]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wen) begin
        dz_r <= cfg_wdata;
      end
      if (cal_wr) begin
        center_r[axis_r] <= cal_center;
        sum_r[axis_r]    <= cal_sum;
        count_r[axis_r]  <= cal_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    axis_r     <= axis_nxt;
    raw_r      <= raw_nxt;
    neg_r      <= neg_nxt;
    rem_r      <= rem_nxt;
    dvs_r      <= dvs_nxt;
    step_r     <= step_nxt;
    quo_r      <= quo_nxt;
    out_axis_r <= out_axis_nxt;
    out_pos_r  <= out_pos_nxt;
    out_ctr_r  <= out_ctr_nxt;
    out_done_r <= out_done_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_ctr_r, out_pos_r, out_axis_r};
  assign out_tuser  = out_done_r;

  `JADM_ASSERT_NXT(a_accept_starts, in_tvalid && in_tready,
                   state_r == jadm_pkg::ST_PREP, "accepted transaction did not start")
  `JADM_ASSERT_NXT(a_div_ends, state_r == jadm_pkg::ST_DIV && step_r == '0,
                   state_r == jadm_pkg::ST_DONE, "divider did not finish after last bit")
  `JADM_ASSERT_NOW(a_pos_range, out_valid_r,
                   out_pos_r <= 8'sd100 && out_pos_r >= -8'sd100, "position out of range")
  `JADM_ASSERT_NOW(a_cal_pos_zero, out_valid_r && out_done_r,
                   out_pos_r == '0, "calibration result carries a position")

endmodule

### tb/joystick_axis_deadzone_mapper_top_test.sv
module joystick_axis_deadzone_mapper_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import jadm_pkg::*;

  localparam int PCT_FULL  = 100;
  localparam int HOLD_LONG = 300;

  typedef struct {
    logic [1:0]        axis;
    logic signed [7:0] position;
    logic [11:0]       center;
    logic              done;
  } axis_result_t;

  typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_ALTERNATE} rx_mode_t;

  class axis_map_scoreboard;
    logic [11:0]  center[AXIS_COUNT];
    logic [16:0]  cal_sum[AXIS_COUNT];
    int           cal_count[AXIS_COUNT];
    int           deadzone;
    axis_result_t expected_q[$];
    int           errors;
    int           maps;
    int           cals;
    int           recenters;

    function new();
      for (int i = 0; i < AXIS_COUNT; i++) begin
        center[i] = CENTER_RESET;
        cal_sum[i] = '0;
        cal_count[i] = 0;
      end
      deadzone = int'(DEADZONE_RESET);
      errors = 0;
      maps = 0;
      cals = 0;
      recenters = 0;
    endfunction

    // Work out the result of one accepted transaction and queue it.
    function void note_input(logic op, logic [1:0] axis, logic [11:0] raw);
      axis_result_t r;
      int diff;
      int span;
      int pct;
      r.axis = axis;
      r.position = '0;
      r.done = 1'b0;
      if (op == OP_MAP) begin
        maps++;
        diff = int'(raw) - int'(center[axis]);
        span = (diff >= 0) ? int'(MAX_RAW) - int'(center[axis]) : int'(center[axis]);
        if (span <= 0) span = 1;
        pct = (diff * PCT_FULL) / span;
        if (pct > PCT_FULL) pct = PCT_FULL;
        if (pct < -PCT_FULL) pct = -PCT_FULL;
        if (pct > -deadzone && pct < deadzone) pct = 0;
        r.position = 8'(pct);
      end else begin
        cals++;
        cal_sum[axis] += 17'(raw);
        cal_count[axis]++;
        if (cal_count[axis] >= CAL_SAMPLES) begin
          center[axis] = 12'(cal_sum[axis] / CAL_SAMPLES);
          cal_sum[axis] = '0;
          cal_count[axis] = 0;
          r.done = 1'b1;
          recenters++;
        end
      end
      r.center = center[axis];
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [23:0] data, logic done);
      axis_result_t e;
      logic signed [7:0] pos;
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: data %h done %0d", data, done);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      pos = data[9:2];
      if (data[1:0] !== e.axis) begin
        $error("axis_out mismatch: expected %0d, actual %0d", e.axis, data[1:0]);
        errors++;
      end
      if (pos !== e.position) begin
        $error("position mismatch: expected %0d, actual %0d", e.position, pos);
        errors++;
      end
      if (data[21:10] !== e.center) begin
        $error("center_now mismatch: expected %0d, actual %0d", e.center, data[21:10]);
        errors++;
      end
      if (done !== e.done) begin
        $error("calibration_done mismatch: expected %0d, actual %0d", e.done, done);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_wen;
  logic [6:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tuser;

  axis_map_scoreboard sb;
  int          hold_off_cycles = 0;
  int          dz_settings = 0;
  logic [11:0] target_center[AXIS_COUNT];
  int          target_spread[AXIS_COUNT];

  joystick_axis_deadzone_mapper_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("joystick_axis_deadzone_mapper_top verification failed");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      sb.note_input(in_tuser, in_tdata[1:0], in_tdata[13:2]);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata, out_tuser);
  end

  // Receiver: random stall segments, plus a long hold-off on request.
  initial begin
    rx_mode_t mode;
    int len;
    int n;
    out_tready <= 1'b0;
    forever begin
      if (hold_off_cycles > 0) begin
        n = hold_off_cycles;
        hold_off_cycles = 0;
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        mode = rx_mode_t'($urandom_range(3));
        len = $urandom_range(8, 64);
        for (int i = 0; i < len; i++) begin
          case (mode)
            RX_FREE:      out_tready <= 1'b1;
            RX_COIN:      out_tready <= 1'($urandom_range(1));
            RX_SPARSE:    out_tready <= ($urandom_range(3) == 0);
            RX_ALTERNATE: out_tready <= 1'(i);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  task automatic send_item(logic op, logic [1:0] axis, logic [11:0] raw);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {2'b00, raw, axis};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic pause_input(int n);
    in_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
  endtask

  task automatic set_deadzone(int value);
    drain_results();
    cfg_wen   <= 1'b1;
    cfg_wdata <= 7'(value);
    @(posedge clk);
    cfg_wen <= 1'b0;
    sb.deadzone = value;
    dz_settings++;
  endtask

  // Finish the open averaging round, then a full one, so the center lands on value.
  task automatic calibrate_exact(logic [1:0] axis, logic [11:0] value);
    int n;
    drain_results();
    n = CAL_SAMPLES - sb.cal_count[axis] + CAL_SAMPLES;
    repeat (n) send_item(OP_CAL, axis, value);
    target_center[axis] = value;
    target_spread[axis] = 0;
  endtask

  function automatic logic [11:0] clip_sample(int v);
    if (v < 0) return '0;
    if (v > int'(MAX_RAW)) return MAX_RAW;
    return 12'(v);
  endfunction

  task automatic send_random_item();
    logic       op;
    logic [1:0] axis;
    int         noise;
    logic [11:0] raw;
    axis = 2'($urandom_range(3));
    op = ($urandom_range(99) < 35) ? OP_CAL : OP_MAP;
    if (op == OP_CAL) begin
      noise = $urandom_range(2 * target_spread[axis]) - target_spread[axis];
      raw = clip_sample(int'(target_center[axis]) + noise);
    end else begin
      case ($urandom_range(7))
        0:       raw = $urandom_range(1) ? MAX_RAW : '0;
        1, 2:    raw = clip_sample(int'(target_center[axis]) + $urandom_range(80) - 40);
        default: raw = 12'($urandom_range(4095));
      endcase
    end
    send_item(op, axis, raw);
  endtask

  initial begin
    int dz_plan[10] = '{4, 0, 100, 127, 1, 99, -1, 50, -1, -1};
    int spreads[4] = '{0, 4, 64, 600};
    int left;
    int burst;
    int gap;
    logic no_gaps;

    sb = new();
    rst_n     <= 1'b0;
    cfg_wen   <= 1'b0;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tuser  <= OP_MAP;
    in_tdata  <= '0;
    for (int i = 0; i < AXIS_COUNT; i++) begin
      target_center[i] = CENTER_RESET;
      target_spread[i] = 64;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: full-scale swings, both sides of the deadzone edge, calibration.
    send_item(OP_MAP, 2'd0, 12'd0);
    send_item(OP_MAP, 2'd1, 12'd4095);
    send_item(OP_MAP, 2'd2, 12'd2048);
    send_item(OP_MAP, 2'd3, 12'd2047);
    send_item(OP_MAP, 2'd0, 12'd2120);
    send_item(OP_MAP, 2'd1, 12'd2130);
    send_item(OP_MAP, 2'd2, 12'd1950);
    send_item(OP_MAP, 2'd3, 12'd1946);
    send_item(OP_MAP, 2'd0, 12'd4000);
    send_item(OP_CAL, 2'd0, 12'd0);
    send_item(OP_CAL, 2'd1, 12'd4095);
    send_item(OP_CAL, 2'd2, 12'd2048);
    send_item(OP_CAL, 2'd3, 12'd4095);
    send_item(OP_CAL, 2'd0, 12'd4095);
    set_deadzone(0);
    send_item(OP_MAP, 2'd1, 12'd2049);
    send_item(OP_MAP, 2'd2, 12'd2060);
    send_item(OP_MAP, 2'd3, 12'd2070);
    send_item(OP_MAP, 2'd0, 12'd2027);
    set_deadzone(100);
    send_item(OP_MAP, 2'd0, 12'd0);
    send_item(OP_MAP, 2'd1, 12'd4095);
    send_item(OP_MAP, 2'd2, 12'd3000);
    set_deadzone(127);
    send_item(OP_MAP, 2'd3, 12'd4095);
    send_item(OP_MAP, 2'd0, 12'd0);

    for (int p = 0; p < 10; p++) begin
      set_deadzone(dz_plan[p] < 0 ? int'($urandom_range(127)) : dz_plan[p]);
      for (int a = 0; a < AXIS_COUNT; a++) begin
        case ($urandom_range(3))
          0:       target_center[a] = '0;
          1:       target_center[a] = MAX_RAW;
          2:       target_center[a] = CENTER_RESET;
          default: target_center[a] = 12'($urandom_range(4095));
        endcase
        target_spread[a] = spreads[$urandom_range(3)];
      end
      if (p == 1) begin
        // center at full scale (span clamps to 1) and center at zero
        calibrate_exact(2'd0, MAX_RAW);
        calibrate_exact(2'd1, '0);
      end
      if (p == 3)
        hold_off_cycles = HOLD_LONG;
      no_gaps = ($urandom_range(3) == 0);
      left = 130;
      while (left > 0) begin
        burst = $urandom_range(1, 16);
        if (burst > left) burst = left;
        repeat (burst) send_random_item();
        left -= burst;
        if (p == 5 && left < 65 && left + burst >= 65)
          drain_results();
        gap = (no_gaps || $urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) pause_input(gap);
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    $display("Covered %0d map and %0d calibration transactions, %0d recenters,",
             sb.maps, sb.cals, sb.recenters);
    $display("over %0d deadzone settings including 0, 100 and 127.", dz_settings);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("joystick_axis_deadzone_mapper_top verification clean");
    end else begin
      $display("joystick_axis_deadzone_mapper_top verification failed");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/jadm_pkg.sv
rtl/core/joystick_axis_deadzone_mapper_top.sv
tb/joystick_axis_deadzone_mapper_top_test.sv
